/* hdl/swmo_pkg.sv */
`timescale 1ns / 1ps

package swmo_pkg;

  localparam int unsigned VALUE_BITS = 12;
  localparam int unsigned WINDOW_MAX = 1024;
  localparam int unsigned TOTAL_BITS = 16;

  localparam int unsigned HIST_DEPTH = 2 ** VALUE_BITS;
  localparam int unsigned HEAD_BITS  = $clog2(WINDOW_MAX);
  localparam int unsigned LEN_BITS   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CNT_BITS   = $clog2(2 * WINDOW_MAX);
  localparam int unsigned HIST_BITS  = 2 * CNT_BITS;
  localparam int unsigned CFG_BITS   = 11;
  localparam int unsigned OVL_BITS   = 11;
  localparam int unsigned FUNC_BITS  = 2;
  localparam int unsigned CMP_BITS   = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;
  localparam int unsigned PADDR_BITS = 3;

  localparam logic [CNT_BITS-1:0]   PAT_CEIL  = CNT_BITS'(2 * WINDOW_MAX - 1);
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  // func codes
  localparam logic [FUNC_BITS-1:0] FUNC_PATTERN = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_TEXT    = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_FINISH  = 2'd2;

  // register indexes (paddr[2])
  localparam logic REG_WINDOW_LEN  = 1'b0;
  localparam logic REG_MIN_MATCHES = 1'b1;

  typedef struct packed {
    logic [FUNC_BITS-1:0]  func;
    logic [VALUE_BITS-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic                  window_full;
    logic                  window_good;
    logic [OVL_BITS-1:0]   overlap;
    logic [TOTAL_BITS-1:0] good_total;
  } out_beat_t;

  // one histogram entry: pattern count and window count of a value
  typedef struct packed {
    logic [CNT_BITS-1:0] pat;
    logic [CNT_BITS-1:0] win;
  } hist_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] len;
    logic [CFG_BITS-1:0] min_matches;
    logic                win_clear;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic clearing;
  } stat_t;

endpackage

/* hdl/swmo_ram.sv */
`timescale 1ns / 1ps

module swmo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/swmo_cfg.sv */
`timescale 1ns / 1ps

module swmo_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swmo_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output swmo_pkg::cfg_t                 cfg_o
);

  logic [swmo_pkg::CFG_BITS-1:0] window_len_q, window_len_d;
  logic [swmo_pkg::CFG_BITS-1:0] min_matches_q, min_matches_d;
  logic                          wr;
  logic                          wr_len;
  logic [swmo_pkg::LEN_BITS-1:0] eff_len;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign wr_len = wr & (paddr[2] == swmo_pkg::REG_WINDOW_LEN);

  always_comb begin
    window_len_d  = window_len_q;
    min_matches_d = min_matches_q;
    if (wr) begin
      case (paddr[2])
        swmo_pkg::REG_WINDOW_LEN:  window_len_d  = pwdata[swmo_pkg::CFG_BITS-1:0];
        swmo_pkg::REG_MIN_MATCHES: min_matches_d = pwdata[swmo_pkg::CFG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q  <= swmo_pkg::CFG_BITS'(1);
      min_matches_q <= swmo_pkg::CFG_BITS'(1);
    end else begin
      window_len_q  <= window_len_d;
      min_matches_q <= min_matches_d;
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[2])
      swmo_pkg::REG_WINDOW_LEN:  prdata = 32'(window_len_q);
      swmo_pkg::REG_MIN_MATCHES: prdata = 32'(min_matches_q);
      default: ;
    endcase
  end

  // effective length: zero means one, clipped at the window maximum
  always_comb begin
    if (window_len_q == '0) begin
      eff_len = swmo_pkg::LEN_BITS'(1);
    end else if (32'(window_len_q) > swmo_pkg::WINDOW_MAX) begin
      eff_len = swmo_pkg::LEN_BITS'(swmo_pkg::WINDOW_MAX);
    end else begin
      eff_len = swmo_pkg::LEN_BITS'(window_len_q);
    end
  end

  assign cfg_o.len         = eff_len;
  assign cfg_o.min_matches = min_matches_q;
  assign cfg_o.win_clear   = wr_len;

endmodule

/* hdl/swmo_core.sv */
`timescale 1ns / 1ps

module swmo_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swmo_pkg::in_beat_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swmo_pkg::out_beat_t out_o,
  input  swmo_pkg::cfg_t      cfg_i,
  output swmo_pkg::stat_t     stat_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOOK = 6'b000010,
    ST_RMV  = 6'b000100,
    ST_INS  = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_CLR  = 6'b100000
  } st_e;

  st_e state_q, state_d;

  logic [swmo_pkg::FUNC_BITS-1:0]  func_q, func_d;
  logic [swmo_pkg::VALUE_BITS-1:0] val_q, val_d;
  logic [swmo_pkg::VALUE_BITS-1:0] old_q, old_d;
  swmo_pkg::hist_t                 hv_q, hv_d;
  logic [swmo_pkg::LEN_BITS-1:0]   fill_q, fill_d;
  logic [swmo_pkg::HEAD_BITS-1:0]  head_q, head_d;
  logic [swmo_pkg::LEN_BITS-1:0]   ovl_q, ovl_d;
  logic [swmo_pkg::TOTAL_BITS-1:0] good_q, good_d;
  logic                            clr_pat_q, clr_pat_d;
  logic [swmo_pkg::VALUE_BITS:0]   clr_cnt_q, clr_cnt_d;
  logic                            clr_wr_q, clr_wr_d;
  logic [swmo_pkg::VALUE_BITS-1:0] clr_waddr_q, clr_waddr_d;
  logic                            out_valid_q, out_valid_d;
  swmo_pkg::out_beat_t             out_q, out_d;

  // memory ports
  logic                              hist_re, hist_we;
  logic [swmo_pkg::VALUE_BITS-1:0]   hist_raddr, hist_waddr;
  swmo_pkg::hist_t                   hist_wdata, hist_rd;
  logic [swmo_pkg::HIST_BITS-1:0]    hist_rdata;
  logic                              dl_re, dl_we;
  logic [swmo_pkg::HEAD_BITS-1:0]    dl_raddr, dl_waddr;
  logic [swmo_pkg::VALUE_BITS-1:0]   dl_wdata, dl_rdata;

  // scratch
  logic                              slot_free;
  logic [swmo_pkg::CNT_BITS-1:0]     cnt_new;
  logic [swmo_pkg::LEN_BITS-1:0]     head_inc;
  logic [swmo_pkg::LEN_BITS-1:0]     ovl_new;
  logic                              full, good;

  assign hist_rd   = swmo_pkg::hist_t'(hist_rdata);
  assign slot_free = !out_valid_q || out_ready_i;
  assign head_inc  = swmo_pkg::LEN_BITS'(head_q) + swmo_pkg::LEN_BITS'(1);

  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    val_d       = val_q;
    old_d       = old_q;
    hv_d        = hv_q;
    fill_d      = fill_q;
    head_d      = head_q;
    ovl_d       = ovl_q;
    good_d      = good_q;
    clr_pat_d   = clr_pat_q;
    clr_cnt_d   = clr_cnt_q;
    clr_wr_d    = 1'b0;
    clr_waddr_d = clr_waddr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    hist_re    = 1'b0;
    hist_raddr = val_q;
    hist_we    = 1'b0;
    hist_waddr = val_q;
    hist_wdata = hv_q;
    dl_re      = 1'b0;
    dl_raddr   = head_q;
    dl_we      = 1'b0;
    dl_waddr   = head_q;
    dl_wdata   = val_q;

    in_ready_o = 1'b0;
    cnt_new    = '0;
    ovl_new    = ovl_q;
    full       = 1'b0;
    good       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d     = in_i.func;
          val_d      = in_i.value;
          hist_re    = 1'b1;
          hist_raddr = in_i.value;
          dl_re      = 1'b1;
          case (in_i.func)
            swmo_pkg::FUNC_PATTERN,
            swmo_pkg::FUNC_TEXT:   state_d = ST_LOOK;
            swmo_pkg::FUNC_FINISH: state_d = ST_FIN;
            default: ;
          endcase
        end
      end

      ST_LOOK: begin
        if (func_q == swmo_pkg::FUNC_PATTERN) begin
          if (hist_rd.pat != swmo_pkg::PAT_CEIL) begin
            cnt_new         = hist_rd.pat + swmo_pkg::CNT_BITS'(1);
            hist_we         = 1'b1;
            hist_wdata.pat  = cnt_new;
            hist_wdata.win  = hist_rd.win;
            if (hist_rd.win >= cnt_new) begin
              ovl_d = ovl_q + swmo_pkg::LEN_BITS'(1);
            end
          end
          state_d = ST_IDLE;
        end else begin
          hv_d   = hist_rd;
          old_d  = dl_rdata;
          dl_we  = 1'b1;
          head_d = (head_inc >= cfg_i.len) ? '0 : swmo_pkg::HEAD_BITS'(head_inc);
          if (fill_q >= cfg_i.len) begin
            // window full: the oldest value drops out first
            hist_re    = 1'b1;
            hist_raddr = dl_rdata;
            state_d    = ST_RMV;
          end else begin
            fill_d  = fill_q + swmo_pkg::LEN_BITS'(1);
            state_d = ST_INS;
          end
        end
      end

      ST_RMV: begin
        if (hist_rd.win != '0) begin
          cnt_new        = hist_rd.win - swmo_pkg::CNT_BITS'(1);
          hist_we        = 1'b1;
          hist_waddr     = old_q;
          hist_wdata.pat = hist_rd.pat;
          hist_wdata.win = cnt_new;
          if (cnt_new < hist_rd.pat && ovl_q != '0) begin
            ovl_d = ovl_q - swmo_pkg::LEN_BITS'(1);
          end
          // same value leaves and enters: insert on the fresh count
          if (old_q == val_q) begin
            hv_d.win = cnt_new;
          end
        end
        state_d = ST_INS;
      end

      ST_INS: begin
        if (slot_free) begin
          cnt_new        = hv_q.win + swmo_pkg::CNT_BITS'(1);
          hist_we        = 1'b1;
          hist_wdata.pat = hv_q.pat;
          hist_wdata.win = cnt_new;
          ovl_new = (cnt_new <= hv_q.pat) ? ovl_q + swmo_pkg::LEN_BITS'(1) : ovl_q;
          full    = fill_q >= cfg_i.len;
          good    = full && (swmo_pkg::CMP_BITS'(ovl_new) >=
                             swmo_pkg::CMP_BITS'(cfg_i.min_matches));
          ovl_d   = ovl_new;
          if (good && good_q != swmo_pkg::TOTAL_MAX) begin
            good_d = good_q + swmo_pkg::TOTAL_BITS'(1);
          end
          out_valid_d       = 1'b1;
          out_d.window_full = full;
          out_d.window_good = good;
          out_d.overlap     = swmo_pkg::OVL_BITS'(ovl_new);
          out_d.good_total  = (good && good_q != swmo_pkg::TOTAL_MAX) ?
                              good_q + swmo_pkg::TOTAL_BITS'(1) : good_q;
          state_d = ST_IDLE;
        end
      end

      ST_FIN: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_d.window_full = 1'b0;
          out_d.window_good = 1'b0;
          out_d.overlap     = '0;
          out_d.good_total  = good_q;
          good_d    = '0;
          fill_d    = '0;
          head_d    = '0;
          ovl_d     = '0;
          clr_pat_d = 1'b1;
          clr_cnt_d = '0;
          state_d   = ST_CLR;
        end
      end

      ST_CLR: begin
        // pipelined sweep: read entry k while writing back entry k-1
        if (!clr_cnt_q[swmo_pkg::VALUE_BITS]) begin
          hist_re     = 1'b1;
          hist_raddr  = clr_cnt_q[swmo_pkg::VALUE_BITS-1:0];
          clr_wr_d    = 1'b1;
          clr_waddr_d = clr_cnt_q[swmo_pkg::VALUE_BITS-1:0];
          clr_cnt_d   = clr_cnt_q + (swmo_pkg::VALUE_BITS + 1)'(1);
        end
        if (clr_wr_q) begin
          hist_we        = 1'b1;
          hist_waddr     = clr_waddr_q;
          hist_wdata.pat = clr_pat_q ? '0 : hist_rd.pat;
          hist_wdata.win = '0;
        end
        if (clr_cnt_q[swmo_pkg::VALUE_BITS] && !clr_wr_q) begin
          clr_pat_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // window_len write empties the window; a pending full clear stays full
    if (cfg_i.win_clear) begin
      fill_d    = '0;
      head_d    = '0;
      ovl_d     = '0;
      clr_cnt_d = '0;
      clr_wr_d  = 1'b0;
      clr_pat_d = (state_q == ST_CLR) ? clr_pat_q : 1'b0;
      state_d   = ST_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      fill_q      <= '0;
      head_q      <= '0;
      ovl_q       <= '0;
      good_q      <= '0;
      clr_pat_q   <= 1'b1;
      clr_cnt_q   <= '0;
      clr_wr_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      ovl_q       <= ovl_d;
      good_q      <= good_d;
      clr_pat_q   <= clr_pat_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_wr_q    <= clr_wr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    val_q       <= val_d;
    old_q       <= old_d;
    hv_q        <= hv_d;
    clr_waddr_q <= clr_waddr_d;
    out_q       <= out_d;
  end

  swmo_ram #(
    .WIDTH (swmo_pkg::HIST_BITS),
    .DEPTH (swmo_pkg::HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  swmo_ram #(
    .WIDTH (swmo_pkg::VALUE_BITS),
    .DEPTH (swmo_pkg::WINDOW_MAX)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .re_i    (dl_re),
    .raddr_i (dl_raddr),
    .rdata_o (dl_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign out_o           = out_q;
  assign stat_o.idle     = (state_q == ST_IDLE);
  assign stat_o.clearing = (state_q == ST_CLR);

endmodule

/* hdl/sliding_window_multiset_overlap.sv */
`timescale 1ns / 1ps

// Sliding-window multiset overlap counter.
// Input channel (in_valid_i/in_ready_o, in_i): func 0 loads a pattern value,
// func 1 pushes a text value, func 2 reports the good-window total and
// clears everything; func 3 is dropped. Output channel (out_valid_o/
// out_ready_i, out_o): one beat per text or finish item.
// Pattern and window counts share one 4096 x 22 histogram RAM (one read and
// one write port); the last window_len text values sit in a 1024-entry
// delay RAM. Items are taken one at a time: a text beat, once the window
// is full, first has the oldest value read, decremented and written back
// before the new one is incremented, all through the histogram RAM's one
// read and one write port. The result is registered in the insert or
// finish step, which waits while the output holds an untaken result.
// Reset, a finish beat and any write to window_len start a sweep of all
// 4096 histogram entries; in_ready_o stays low meanwhile.
// A finish clears pattern and window counts, a window_len write only the
// window counts. Config registers: window_len at 0x0, min_matches at 0x4.
// A stalled result sits in the output register; the block still accepts
// the next beat and holds it at its last step until the result is taken.
module sliding_window_multiset_overlap (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  swmo_pkg::in_beat_t              in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output swmo_pkg::out_beat_t             out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swmo_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  swmo_pkg::cfg_t  cfg;
  swmo_pkg::stat_t stat;

  swmo_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swmo_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_i       (cfg),
    .stat_o      (stat)
  );

`ifndef SYNTHESIS
  // no beat is taken during a histogram sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !in_ready_o)
    else $error("input accepted during clear sweep");

  // a window_len write always starts a sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && (paddr[2] == swmo_pkg::REG_WINDOW_LEN)
    |=> stat.clearing)
    else $error("window_len write did not empty window");

  // a finish beat moves the block out of idle (its sweep follows once the result is out)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.func == swmo_pkg::FUNC_FINISH) |=> !stat.idle)
    else $error("finish beat left block idle");

  // only a full window can be good
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.window_good |-> out_o.window_full)
    else $error("good window reported while not full");
`endif

endmodule

/* tb/swmo_overlap_check.sv */
`timescale 1ns / 1ps

// Watches both streams and the register port, keeps its own copy of the
// histograms and window, and compares every result beat with the oldest
// predicted one.
module swmo_overlap_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  swmo_pkg::in_beat_t              in_beat_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  swmo_pkg::out_beat_t             out_beat_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [swmo_pkg::PADDR_BITS-1:0] paddr_i,
  input  logic [31:0]                     pwdata_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);
  import swmo_pkg::*;

  logic [CNT_BITS-1:0]   pat_cnt   [HIST_DEPTH];
  logic [CNT_BITS-1:0]   win_cnt   [HIST_DEPTH];
  logic [VALUE_BITS-1:0] text_line [WINDOW_MAX];
  int unsigned           head;
  int unsigned           fill;
  int unsigned           ovl;
  logic [TOTAL_BITS-1:0] goods;
  logic [CFG_BITS-1:0]   len_reg;
  logic [CFG_BITS-1:0]   min_reg;
  out_beat_t             tally_q [$];
  int unsigned           seen = 0;
  int unsigned           errs = 0;

  assign errors_o = errs;

  function automatic int unsigned live_len();
    if (len_reg == '0) return 1;
    if (len_reg > WINDOW_MAX) return WINDOW_MAX;
    return len_reg;
  endfunction

  task automatic empty_window();
    foreach (win_cnt[k]) win_cnt[k] = '0;
    head = 0;
    fill = 0;
    ovl  = 0;
  endtask

  task automatic report_mismatch(input string msg);
    if (errs < 40) $display("%0t: MISMATCH %s", $time, msg);
    errs++;
  endtask

  // advance the shadow state by one accepted beat, queue its result if any
  task automatic tally_beat(input in_beat_t b);
    int unsigned           lim;
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] old;
    out_beat_t             r;
    lim = live_len();
    v   = b.value;
    r   = '0;
    case (b.func)
      FUNC_PATTERN: begin
        if (pat_cnt[v] < PAT_CEIL) begin
          pat_cnt[v]++;
          if (win_cnt[v] >= pat_cnt[v]) ovl++;
        end
      end
      FUNC_TEXT: begin
        if (fill >= lim) begin
          old = text_line[head];
          if (win_cnt[old] > 0) begin
            win_cnt[old]--;
            if (win_cnt[old] < pat_cnt[old] && ovl > 0) ovl--;
          end
        end else begin
          fill++;
        end
        text_line[head] = v;
        head++;
        if (head >= lim) head = 0;
        win_cnt[v]++;
        if (win_cnt[v] <= pat_cnt[v]) ovl++;
        r.window_full = (fill >= lim);
        r.window_good = r.window_full && (ovl >= min_reg);
        if (r.window_good && goods != TOTAL_MAX) goods++;
        r.overlap    = OVL_BITS'(ovl);
        r.good_total = goods;
        tally_q.push_back(r);
      end
      FUNC_FINISH: begin
        r.good_total = goods;
        tally_q.push_back(r);
        foreach (pat_cnt[k]) pat_cnt[k] = '0;
        empty_window();
        goods = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    seen++;
    if (tally_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", seen));
      return;
    end
    want = tally_q.pop_front();
    if (got.window_full !== want.window_full)
      report_mismatch($sformatf("result %0d window_full: got %b want %b",
                                seen, got.window_full, want.window_full));
    if (got.window_good !== want.window_good)
      report_mismatch($sformatf("result %0d window_good: got %b want %b",
                                seen, got.window_good, want.window_good));
    if (got.overlap !== want.overlap)
      report_mismatch($sformatf("result %0d overlap: got %0d want %0d",
                                seen, got.overlap, want.overlap));
    if (got.good_total !== want.good_total)
      report_mismatch($sformatf("result %0d good_total: got %0d want %0d",
                                seen, got.good_total, want.good_total));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (pat_cnt[k]) pat_cnt[k] = '0;
      empty_window();
      goods   = '0;
      len_reg = CFG_BITS'(1);
      min_reg = CFG_BITS'(1);
      tally_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[PADDR_BITS-1] == REG_WINDOW_LEN) begin
          len_reg = pwdata_i[CFG_BITS-1:0];
          empty_window();
        end else begin
          min_reg = pwdata_i[CFG_BITS-1:0];
        end
      end
      // a result always belongs to an earlier accepted beat, so pop before push
      if (out_valid_i && out_ready_i) check_result(out_beat_i);
      if (in_valid_i && in_ready_i) tally_beat(in_beat_i);
    end
    pending_o <= tally_q.size();
  end

endmodule

/* tb/sliding_window_multiset_overlap_test.sv */
`timescale 1ns / 1ps

// Stimulus and verdict. Checking lives in swmo_overlap_check.
module sliding_window_multiset_overlap_test;
  import swmo_pkg::*;

  // the one func code the block drops
  localparam logic [FUNC_BITS-1:0] FUNC_SPARE = 2'd3;
  // a pattern beat gives no result and may still be in flight when the
  // last result shows up; this margin lets it settle
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_beat_t              in_beat   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_beat;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [PADDR_BITS-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;
  int unsigned           results_due;
  int unsigned           mismatches;
  bit                    calm      = 1'b0;  // set: neither side idles

  sliding_window_multiset_overlap dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  swmo_overlap_check check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_beat_i  (out_beat),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (results_due),
    .errors_o    (mismatches)
  );

  always #5 clk = ~clk;

  // an idle roll, true 32 times in a hundred unless calm, on either side
  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  // span 0: full 12-bit range; otherwise a small alphabet so counts collide
  function automatic logic [VALUE_BITS-1:0] pick_value(input int unsigned span);
    if (span == 0) return VALUE_BITS'($urandom);
    return VALUE_BITS'($urandom_range(span - 1));
  endfunction

  // register word, sometimes with junk above the 11 live bits
  function automatic logic [31:0] cfg_word(input int unsigned val);
    if ($urandom_range(1) == 1) return (32'($urandom) << CFG_BITS) | val;
    return val;
  endfunction

  // receiver: random backpressure
  always @(posedge clk) out_ready <= !idle_roll();

  // one input beat; valid stays up into the next beat unless a gap is rolled
  task automatic push_beat(input logic [FUNC_BITS-1:0] func,
                           input logic [VALUE_BITS-1:0] value);
    in_beat_t b;
    b.func  = func;
    b.value = value;
    if (idle_roll()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (idle_roll());
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait until every predicted result has been taken
  task automatic quiesce(input bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write only when the block is idle: drained, and out of any
  // histogram sweep (ready back high)
  task automatic write_reg(input logic idx, input logic [31:0] data);
    quiesce(1'b1);
    while (!in_ready) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_BITS'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one random phase: fresh window settings, a pattern, then a text stream
  // sprinkled with late pattern beats, noise, dropped codes and finishes
  task automatic run_round();
    int unsigned len;
    int unsigned span;
    int unsigned n;
    int unsigned roll;
    int unsigned pause_at;
    len  = ($urandom_range(3) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
    span = ($urandom_range(4) == 0) ? 0 : $urandom_range(2, 12);
    write_reg(REG_WINDOW_LEN, cfg_word(len));
    write_reg(REG_MIN_MATCHES, cfg_word($urandom_range(0, len + 1)));
    repeat ($urandom_range(len, 2 * len)) push_beat(FUNC_PATTERN, pick_value(span));
    n        = $urandom_range(100, 140);
    pause_at = $urandom_range(n - 1);
    for (int k = 0; k < n; k++) begin
      // sender holds off until the pipe is empty, then resumes
      if (k == pause_at) quiesce(1'b0);
      roll = $urandom_range(99);
      if (roll < 80)      push_beat(FUNC_TEXT, pick_value(span));
      else if (roll < 88) push_beat(FUNC_PATTERN, pick_value(span));
      else if (roll < 92) push_beat(FUNC_TEXT, pick_value(0));
      else if (roll < 96) push_beat(FUNC_SPARE, pick_value(0));
      else if (roll < 98) push_beat(FUNC_PATTERN, pick_value(0));
      else                push_beat(FUNC_FINISH, pick_value(0));
    end
  endtask

  initial begin
    logic [VALUE_BITS-1:0] seq [48];
    bit                    stuck;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed, reset settings (length 1, need 1) ---
    push_beat(FUNC_TEXT, '0);             // text with an empty pattern
    push_beat(FUNC_SPARE, '1);            // dropped, no beat out
    push_beat(FUNC_PATTERN, '0);          // window already holds a 0: overlap up
    push_beat(FUNC_PATTERN, '1);
    push_beat(FUNC_PATTERN, '1);
    push_beat(FUNC_TEXT, '1);
    push_beat(FUNC_TEXT, '1);
    push_beat(FUNC_TEXT, 12'hAAA);
    push_beat(FUNC_TEXT, 12'h555);
    push_beat(FUNC_FINISH, '0);
    push_beat(FUNC_TEXT, 12'h555);        // after the clear
    write_reg(REG_WINDOW_LEN, 32'd0);     // zero length acts as one
    write_reg(REG_MIN_MATCHES, 32'd0);    // every full window is good
    repeat (3) push_beat(FUNC_TEXT, 12'd7);
    write_reg(REG_MIN_MATCHES, 32'd2047); // never reachable
    write_reg(REG_WINDOW_LEN, 32'd1024);
    push_beat(FUNC_PATTERN, 12'd3);
    push_beat(FUNC_TEXT, 12'd3);
    push_beat(FUNC_TEXT, 12'd3);
    push_beat(FUNC_FINISH, '0);

    // --- oversized length (clamps to 1024), text run equal to the pattern ---
    write_reg(REG_WINDOW_LEN, 32'd2047);
    write_reg(REG_MIN_MATCHES, 32'd40);
    foreach (seq[k]) begin
      seq[k] = pick_value(64);
      push_beat(FUNC_PATTERN, seq[k]);
    end
    foreach (seq[k]) push_beat(FUNC_TEXT, seq[k]);
    push_beat(FUNC_FINISH, '0);

    // --- random phases, one of them with no idling on either side ---
    for (int r = 0; r < 6; r++) begin
      calm = (r == 2);
      run_round();
    end
    calm = 1'b0;
    push_beat(FUNC_FINISH, '0);

    // drain, then a short tail to catch stray beats
    in_valid <= 1'b0;
    @(posedge clk);
    for (int c = 0; c < 20000 && results_due != 0; c++) @(posedge clk);
    stuck = (results_due != 0);
    repeat (20) @(posedge clk);
    if (!stuck && mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #(64'd50_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sliding_window_multiset_overlap.f */
hdl/swmo_pkg.sv
hdl/swmo_ram.sv
hdl/swmo_cfg.sv
hdl/swmo_core.sv
hdl/sliding_window_multiset_overlap.sv
tb/swmo_overlap_check.sv
tb/sliding_window_multiset_overlap_test.sv
